// ===== src/pkhm_pkg.sv =====
// Package for the pointer-keyed hash map: request, status and slot mark codes,
// plus the default sizes used by the top level. No dependencies.
package pkhm_pkg;

   localparam int DEF_CAPACITY   = 1024;
   localparam int DEF_KEY_BITS   = 48;
   localparam int DEF_VALUE_BITS = 64;

   localparam int FILL_BITS = 11;
   localparam logic [FILL_BITS-1:0] FILL_RESET = 11'd768;

   localparam logic [1:0] REQ_SET   = 2'd0;
   localparam logic [1:0] REQ_GET   = 2'd1;
   localparam logic [1:0] REQ_DEL   = 2'd2;
   localparam logic [1:0] REQ_CLEAR = 2'd3;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_FULL       = 2'd1;
   localparam logic [1:0] ST_ZERO_KEY   = 2'd2;
   localparam logic [1:0] ST_ZERO_VALUE = 2'd3;

   localparam logic [1:0] MARK_EMPTY = 2'd0;
   localparam logic [1:0] MARK_LIVE  = 2'd1;
   localparam logic [1:0] MARK_TOMB  = 2'd2;

   localparam logic [2:0] CSR_FILL_LIMIT = 3'd0;

endpackage

// ===== src/pkhm_slot_ram.sv =====
// Slot memory of the hash map: one write port, one read port, registered read.
// Depends on nothing; the top level decides the word layout.
module pkhm_slot_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 114
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pointer_key_hash_map_unit.sv =====
// Top level of the pointer-keyed hash map with linear probing and tombstones.
// Depends on pkhm_pkg and pkhm_slot_ram.
//
//   channel   direction  handshake          payload
//   req_*     in         tvalid/tready      tuser: req_type; tdata: key, new_value
//   rsp_*     out        tvalid/tready      tuser: status; tdata: hit, value_out
//   csr_*     in         APB, pready high   fill_limit at byte address 0
//
// An item is accepted in S_IDLE, then probed slot by slot in S_PROBE (the slot memory
// returns one word per cycle), and hands its result over from S_RESP to the output
// register. With a capacity that is not a power of two, the home slot is worked out
// in S_HASH first, four key bits per cycle.
// A clear sweeps the slot memory one entry per cycle. The same sweep runs after
// reset; no item is accepted while it runs, but CSR writes are.
// A result waits in the output register while the next item is already taken.
module pointer_key_hash_map_unit
   import pkhm_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int KEY_BITS   = DEF_KEY_BITS,
   parameter int VALUE_BITS = DEF_VALUE_BITS,
   localparam int REQ_DW    = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
   localparam int RSP_DW    = ((1 + VALUE_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DW-1:0]     req_tdata,   // key, new_value (from bit 0 up)
   input  logic [1:0]            req_tuser,   // req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DW-1:0]     rsp_tdata,   // hit, value_out (from bit 0 up)
   output logic [1:0]            rsp_tuser,   // status
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int AW      = $clog2(CAPACITY);
   localparam int MW      = 2 + KEY_BITS + VALUE_BITS;
   localparam int OCW     = AW + 1;
   localparam int CMPW    = ((OCW > FILL_BITS) ? OCW : FILL_BITS) + 1;
   localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
   localparam int HB      = KEY_BITS - 3;
   localparam int HSTEPS  = (HB + 3) / 4;
   localparam int HSW     = 4 * HSTEPS;
   localparam int HCW     = $clog2(HSTEPS + 1);
   localparam int RW      = AW + 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
   localparam logic [RW-1:0] CAP_R    = RW'(CAPACITY);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_HASH  = 3'd1;
   localparam logic [2:0] S_PROBE = 3'd2;
   localparam logic [2:0] S_CLEAR = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [FILL_BITS-1:0]  fill_ff;
   logic [OCW-1:0]        occ_ff, occ_in;
   logic [1:0]            type_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [AW-1:0]         cnt_ff, cnt_in;
   logic                  tomb_seen_ff, tomb_seen_in;
   logic [AW-1:0]         tomb_ff, tomb_in;
   logic [HSW-1:0]        hsh_ff, hsh_in;
   logic [RW-1:0]         hrem_ff, hrem_in;
   logic [HCW-1:0]        hcnt_ff, hcnt_in;
   logic                  clr_resp_ff, clr_resp_in;
   logic                  res_hit_ff, res_hit_in;
   logic [VALUE_BITS-1:0] res_val_ff, res_val_in;
   logic [1:0]            res_st_ff, res_st_in;
   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic [VALUE_BITS-1:0] rsp_val_ff;
   logic [1:0]            rsp_st_ff;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [MW-1:0]         wr_data;
   logic [AW-1:0]         rd_addr;
   logic [MW-1:0]         rd_data;

   logic [KEY_BITS-1:0]   in_key;
   logic [VALUE_BITS-1:0] in_val;
   logic                  accept;
   logic                  rsp_free;
   logic [RW-1:0]         hstep;

   logic [1:0]            d_mark;
   logic [KEY_BITS-1:0]   d_key;
   logic [VALUE_BITS-1:0] d_val;

   assign in_key   = req_tdata[KEY_BITS-1:0];
   assign in_val   = req_tdata[KEY_BITS +: VALUE_BITS];
   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   assign d_mark = rd_data[MW-1 -: 2];
   assign d_key  = rd_data[VALUE_BITS +: KEY_BITS];
   assign d_val  = rd_data[VALUE_BITS-1:0];

   // Four restoring remainder steps per cycle on the shifted key.
   always_comb begin
      hstep = hrem_ff;
      for (int j = 0; j < 4; j++) begin
         hstep = {hstep[RW-2:0], hsh_ff[HSW-1-j]};
         if (hstep >= CAP_R) begin
            hstep = hstep - CAP_R;
         end
      end
   end

   pkhm_slot_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (MW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      logic live_match;
      logic is_empty;
      logic have_free;
      logic free_empty;
      logic [AW-1:0] free_slot;
      logic over;

      state_in     = state_ff;
      occ_in       = occ_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      tomb_seen_in = tomb_seen_ff;
      tomb_in      = tomb_ff;
      hsh_in       = hsh_ff;
      hrem_in      = hrem_ff;
      hcnt_in      = hcnt_ff;
      clr_resp_in  = clr_resp_ff;
      res_hit_in   = res_hit_ff;
      res_val_in   = res_val_ff;
      res_st_in    = res_st_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = {MARK_LIVE, key_ff, val_ff};
      rd_addr      = idx_ff;

      live_match = (d_mark == MARK_LIVE) && (d_key == key_ff);
      is_empty   = (d_mark == MARK_EMPTY);
      have_free  = is_empty || tomb_seen_ff || (d_mark == MARK_TOMB);
      free_empty = is_empty && !tomb_seen_ff;
      free_slot  = tomb_seen_ff ? tomb_ff : idx_ff;
      over       = (CMPW'(occ_ff) + CMPW'(1)) > CMPW'(fill_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_hit_in   = 1'b0;
               res_val_in   = '0;
               res_st_in    = ST_OK;
               cnt_in       = '0;
               tomb_seen_in = 1'b0;
               hsh_in       = HSW'(in_key >> 3);
               hrem_in      = '0;
               hcnt_in      = '0;
               idx_in       = AW'(in_key >> 3);
               rd_addr      = AW'(in_key >> 3);
               if (req_tuser == REQ_CLEAR) begin
                  idx_in      = '0;
                  clr_resp_in = 1'b1;
                  state_in    = S_CLEAR;
               end else if (in_key == '0) begin
                  res_st_in = ST_ZERO_KEY;
                  state_in  = S_RESP;
               end else if (req_tuser == REQ_SET && in_val == '0) begin
                  res_st_in = ST_ZERO_VALUE;
                  state_in  = S_RESP;
               end else if (IS_POW2) begin
                  state_in = S_PROBE;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            hrem_in = hstep;
            hsh_in  = hsh_ff << 4;
            hcnt_in = hcnt_ff + HCW'(1);
            if (hcnt_ff == HCW'(HSTEPS - 1)) begin
               idx_in   = AW'(hstep);
               rd_addr  = AW'(hstep);
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (live_match) begin
               res_hit_in = 1'b1;
               res_val_in = d_val;
               if (type_ff == REQ_SET) begin
                  wr_en = 1'b1;
               end else if (type_ff == REQ_DEL) begin
                  wr_en   = 1'b1;
                  wr_data = {MARK_TOMB, d_key, d_val};
               end
               state_in = S_RESP;
            end else if (is_empty || cnt_ff == LAST_IDX) begin
               if (type_ff == REQ_SET) begin
                  if (!have_free || (free_empty && over)) begin
                     res_st_in = ST_FULL;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = free_slot;
                     if (free_empty) begin
                        occ_in = occ_ff + OCW'(1);
                     end
                  end
               end
               state_in = S_RESP;
            end else begin
               if (d_mark == MARK_TOMB && !tomb_seen_ff) begin
                  tomb_seen_in = 1'b1;
                  tomb_in      = idx_ff;
               end
               idx_in  = (idx_ff == LAST_IDX) ? '0 : idx_ff + AW'(1);
               rd_addr = idx_in;
               cnt_in  = cnt_ff + AW'(1);
            end
         end
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = {MARK_EMPTY, {(KEY_BITS + VALUE_BITS){1'b0}}};
            idx_in  = idx_ff + AW'(1);
            if (idx_ff == LAST_IDX) begin
               occ_in   = '0;
               state_in = clr_resp_ff ? S_RESP : S_IDLE;
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               clr_resp_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         clr_resp_ff  <= 1'b0;
         occ_ff       <= '0;
         fill_ff      <= FILL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         clr_resp_ff <= clr_resp_in;
         occ_ff      <= occ_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == CSR_FILL_LIMIT[0]) begin
            fill_ff <= csr_pwdata[FILL_BITS-1:0];
         end
         if (state_ff == S_RESP && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      tomb_seen_ff <= tomb_seen_in;
      tomb_ff      <= tomb_in;
      hsh_ff       <= hsh_in;
      hrem_ff      <= hrem_in;
      hcnt_ff      <= hcnt_in;
      res_hit_ff   <= res_hit_in;
      res_val_ff   <= res_val_in;
      res_st_ff    <= res_st_in;
      if (accept) begin
         type_ff <= req_tuser;
         key_ff  <= in_key;
         val_ff  <= in_val;
      end
      if (state_ff == S_RESP && rsp_free) begin
         rsp_hit_ff <= res_hit_ff;
         rsp_val_ff <= res_val_ff;
         rsp_st_ff  <= res_st_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DW'({rsp_val_ff, rsp_hit_ff});
   assign rsp_tuser  = rsp_st_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_FILL_LIMIT[0]) ? 32'(fill_ff) : 32'd0;

endmodule
